FILE: design/motor_feedback_multiturn_tracker_unit_defines.svh
// Assertion macros shared by the tracker's checker.
// No dependencies; include by bare file name.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MFMT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tracker check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define MFMT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tracker check failed: next-cycle implication");

`endif

FILE: design/mfmt_pkg.sv
// Package for the multi-turn tracker: field widths, reset values and
// configuration register indexes. No dependencies.
package mfmt_pkg;

    localparam int ENC_W     = 16;
    localparam int WORD_W    = 16;
    localparam int TEMP_W    = 8;
    localparam int LEN_W     = 4;
    localparam int TURN_W    = 32;
    localparam int POS_W     = 48;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int HALF_TURN_COUNTS_DEF = 4096;

    localparam logic [LEN_W-1:0]  MIN_FRAME_BYTES   = 4'd8;
    localparam logic [WORD_W-1:0] TIMEOUT_RESET     = 16'd200;
    localparam logic [WORD_W-1:0] STARTUP_RESET     = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REVERSE_DIRECTION = 2'd0,
        REG_TIMEOUT_TICKS     = 2'd1,
        REG_STARTUP_TICKS     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

endpackage

FILE: design/mfmt_channels.sv
// Valid/ready channel interfaces for the tracker's feedback input and
// result output. Depends on mfmt_pkg.
interface mfmt_feedback_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [mfmt_pkg::LEN_W-1:0]          frame_length;
    logic [mfmt_pkg::ENC_W-1:0]          encoder_word;
    logic signed [mfmt_pkg::WORD_W-1:0]  speed_word;
    logic signed [mfmt_pkg::WORD_W-1:0]  current_word;
    logic [mfmt_pkg::TEMP_W-1:0]         temperature_byte;

    modport source (
        output valid, opcode, frame_length, encoder_word, speed_word,
               current_word, temperature_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, frame_length, encoder_word, speed_word,
               current_word, temperature_byte,
        output ready
    );
endinterface

interface mfmt_result_if;
    logic                                valid;
    logic                                ready;
    logic                                online;
    logic                                went_offline;
    logic [mfmt_pkg::ENC_W-1:0]          encoder_now;
    logic signed [mfmt_pkg::WORD_W-1:0]  speed_signed;
    logic signed [mfmt_pkg::WORD_W-1:0]  current_signed;
    logic [mfmt_pkg::TEMP_W-1:0]         temperature_now;
    logic signed [mfmt_pkg::TURN_W-1:0]  turn_count;
    logic signed [mfmt_pkg::POS_W-1:0]   total_position;

    modport source (
        output valid, online, went_offline, encoder_now, speed_signed,
               current_signed, temperature_now, turn_count, total_position,
        input  ready
    );
    modport sink (
        input  valid, online, went_offline, encoder_now, speed_signed,
               current_signed, temperature_now, turn_count, total_position,
        output ready
    );
endinterface

FILE: design/motor_feedback_multiturn_tracker_unit.sv
// Multi-turn encoder tracker for a motor feedback stream.
// Depends on mfmt_pkg and the channel interfaces in mfmt_channels.sv.
//
// Usage:
//   feedback (sink): one word per feedback frame (opcode 0) or timer tick
//   (opcode 1). Frames shorter than 8 bytes leave the state untouched.
//   result (source): exactly one word per accepted input word, carrying the
//   state after that input: online flag, offline event, held readings with
//   direction sign applied, turn count and total position in counts.
//   cfg_*: write-only register port (reverse_direction, timeout_ticks, startup_ticks);
//   the user must write it only while the block is idle; the block does not enforce this.
// Latency: a result is valid the cycle after its input word is accepted.
// Throughput: one word per cycle when not stalled; the state update and the result
//   register load in the same edge, so the next word sees the updated state.
// Stall: a pending result sits in the output register; a new word is taken
//   in the cycle the receiver takes the pending one (or when none is held).
// Reset: asynchronous, active low. The block starts offline with all
//   measurements zero and the countdown loaded with startup_ticks.
module motor_feedback_multiturn_tracker_unit #(
    parameter int HALF_TURN_COUNTS = mfmt_pkg::HALF_TURN_COUNTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    mfmt_feedback_if.sink                           feedback,
    mfmt_result_if.source                           result,
    input  logic                                    cfg_we,
    input  logic [mfmt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mfmt_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int TURN_COUNTS = 2 * HALF_TURN_COUNTS;
    localparam int DELTA_W     = mfmt_pkg::ENC_W + 2;
    localparam int PROD_W      = mfmt_pkg::TURN_W + DELTA_W;
    localparam logic signed [DELTA_W-1:0] HALF_S  = DELTA_W'(HALF_TURN_COUNTS);
    localparam logic signed [DELTA_W-1:0] TURNS_S = DELTA_W'(TURN_COUNTS);

    // configuration
    logic                              reverse_reg;
    logic [mfmt_pkg::WORD_W-1:0]       timeout_reg;
    logic [mfmt_pkg::WORD_W-1:0]       startup_reg;

    // tracker state
    logic                              online_reg, online_next;
    logic                              expired_reg, expired_next;
    logic [mfmt_pkg::WORD_W-1:0]       countdown_reg, countdown_next;
    logic [mfmt_pkg::ENC_W-1:0]        encoder_reg, encoder_next;
    logic [mfmt_pkg::WORD_W-1:0]       speed_reg, speed_next;
    logic [mfmt_pkg::WORD_W-1:0]       current_reg, current_next;
    logic [mfmt_pkg::TEMP_W-1:0]       temp_reg, temp_next;
    logic signed [mfmt_pkg::TURN_W-1:0] turns_reg, turns_next;
    logic                              went_next;

    // result register
    logic                              out_valid_reg;
    logic                              out_online_reg;
    logic                              out_went_reg;
    logic [mfmt_pkg::ENC_W-1:0]        out_encoder_reg;
    logic [mfmt_pkg::WORD_W-1:0]       out_speed_reg;
    logic [mfmt_pkg::WORD_W-1:0]       out_current_reg;
    logic [mfmt_pkg::TEMP_W-1:0]       out_temp_reg;
    logic signed [mfmt_pkg::TURN_W-1:0] out_turns_reg;
    logic signed [mfmt_pkg::POS_W-1:0]  out_pos_reg;

    logic                              accept;
    logic                              frame_ok;
    logic [mfmt_pkg::WORD_W-1:0]       countdown_dec;
    logic signed [DELTA_W-1:0]         delta_raw, delta_dir;
    logic signed [PROD_W-1:0]          turn_prod;
    logic [mfmt_pkg::POS_W-1:0]        enc_ext;
    logic [mfmt_pkg::POS_W-1:0]        pos_next;

    assign feedback.ready = !out_valid_reg || result.ready;
    assign accept         = feedback.valid && feedback.ready;

    assign frame_ok = (feedback.opcode == mfmt_pkg::OP_FRAME)
                   && (feedback.frame_length >= mfmt_pkg::MIN_FRAME_BYTES);

    // encoder jump, sign-adjusted; last minus new
    assign delta_raw = signed'({2'b00, encoder_reg}) - signed'({2'b00, feedback.encoder_word});
    assign delta_dir = reverse_reg ? -delta_raw : delta_raw;

    assign countdown_dec = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;

    function automatic logic [mfmt_pkg::WORD_W-1:0] WORD_W_NEG(
        input logic [mfmt_pkg::WORD_W-1:0] v);
        return '0 - v;
    endfunction

    always_comb
    begin
        online_next    = online_reg;
        expired_next   = expired_reg;
        countdown_next = countdown_reg;
        encoder_next   = encoder_reg;
        speed_next     = speed_reg;
        current_next   = current_reg;
        temp_next      = temp_reg;
        turns_next     = turns_reg;
        went_next      = 1'b0;
        if (feedback.opcode == mfmt_pkg::OP_TICK)
        begin
            countdown_next = countdown_dec;
            if (countdown_dec == '0 && !expired_reg)
            begin
                online_next  = 1'b0;
                expired_next = 1'b1;
                encoder_next = '0;
                speed_next   = '0;
                current_next = '0;
                temp_next    = '0;
                turns_next   = '0;
                went_next    = 1'b1;
            end
        end
        else if (frame_ok)
        begin
            encoder_next   = feedback.encoder_word;
            speed_next     = reverse_reg ? WORD_W_NEG(feedback.speed_word)
                                         : feedback.speed_word;
            current_next   = reverse_reg ? WORD_W_NEG(feedback.current_word)
                                         : feedback.current_word;
            temp_next      = feedback.temperature_byte;
            if (online_reg)
            begin
                if (delta_dir > HALF_S)
                    turns_next = turns_reg + 32'sd1;
                else if (delta_dir < -HALF_S)
                    turns_next = turns_reg - 32'sd1;
            end
            online_next    = 1'b1;
            countdown_next = timeout_reg;
            expired_next   = 1'b0;
        end
    end

    assign turn_prod = turns_next * TURNS_S;
    assign enc_ext   = {{(mfmt_pkg::POS_W - mfmt_pkg::ENC_W){1'b0}}, encoder_next};
    assign pos_next  = turn_prod[mfmt_pkg::POS_W-1:0]
                     + (reverse_reg ? ('0 - enc_ext) : enc_ext);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            timeout_reg <= mfmt_pkg::TIMEOUT_RESET;
            startup_reg <= mfmt_pkg::STARTUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfmt_pkg::REG_REVERSE_DIRECTION: reverse_reg <= cfg_data[0];
                mfmt_pkg::REG_TIMEOUT_TICKS:     timeout_reg <= cfg_data;
                mfmt_pkg::REG_STARTUP_TICKS:     startup_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg    <= 1'b0;
            expired_reg   <= 1'b0;
            countdown_reg <= mfmt_pkg::STARTUP_RESET;
            encoder_reg   <= '0;
            speed_reg     <= '0;
            current_reg   <= '0;
            temp_reg      <= '0;
            turns_reg     <= '0;
        end
        else if (accept)
        begin
            online_reg    <= online_next;
            expired_reg   <= expired_next;
            countdown_reg <= countdown_next;
            encoder_reg   <= encoder_next;
            speed_reg     <= speed_next;
            current_reg   <= current_next;
            temp_reg      <= temp_next;
            turns_reg     <= turns_next;
        end
        else if (cfg_we && cfg_index == mfmt_pkg::REG_STARTUP_TICKS
                 && !online_reg && !expired_reg)
        begin
            // still in startup: new startup value restarts the countdown
            countdown_reg <= cfg_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_online_reg  <= online_next;
            out_went_reg    <= went_next;
            out_encoder_reg <= encoder_next;
            out_speed_reg   <= speed_next;
            out_current_reg <= current_next;
            out_temp_reg    <= temp_next;
            out_turns_reg   <= turns_next;
            out_pos_reg     <= signed'(pos_next);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.online          = out_online_reg;
    assign result.went_offline    = out_went_reg;
    assign result.encoder_now     = out_encoder_reg;
    assign result.speed_signed    = signed'(out_speed_reg);
    assign result.current_signed  = signed'(out_current_reg);
    assign result.temperature_now = out_temp_reg;
    assign result.turn_count      = out_turns_reg;
    assign result.total_position  = out_pos_reg;

endmodule

FILE: design/mfmt_checker.sv
// Port-level checks for the multi-turn tracker, bound to the top level.
// Depends on mfmt_pkg and motor_feedback_multiturn_tracker_unit_defines.svh.
`include "motor_feedback_multiturn_tracker_unit_defines.svh"

module mfmt_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic                                    online,
    input logic                                    went_offline,
    input logic [mfmt_pkg::ENC_W-1:0]              encoder_now,
    input logic signed [mfmt_pkg::TURN_W-1:0]      turn_count,
    input logic signed [mfmt_pkg::POS_W-1:0]       total_position
);

    logic in_word;
    logic out_stall;

    assign in_word   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // a held result is not dropped while the receiver stalls
    `MFMT_ASSERT_NEXT(a_result_held, clk, rst_n, out_stall, out_valid)

    // every accepted word yields a result in the next cycle
    `MFMT_ASSERT_NEXT(a_word_result, clk, rst_n, in_word, out_valid)

    // the offline event reports a cleared tracker
    `MFMT_ASSERT_IMPLY(a_offline_clear, clk, rst_n, out_valid && went_offline,
        !online && encoder_now == '0 && turn_count == '0 && total_position == '0)

    // turns only move while online, and going offline clears them
    `MFMT_ASSERT_IMPLY(a_offline_no_turns, clk, rst_n, out_valid && !online,
        turn_count == '0)

endmodule

bind motor_feedback_multiturn_tracker_unit mfmt_checker u_mfmt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (feedback.valid),
    .in_ready       (feedback.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .online         (result.online),
    .went_offline   (result.went_offline),
    .encoder_now    (result.encoder_now),
    .turn_count     (result.turn_count),
    .total_position (result.total_position)
);
